// ===== hdl/rfgm_pkg.sv =====
// Shared types, codes and defaults of the role FIFO group matcher.
package rfgm_pkg;

  localparam int NUM_ROLES      = 3;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF   = 16;

  localparam int MODE_W   = 2;
  localparam int ROLE_W   = 2;
  localparam int PID_W    = 16;
  localparam int FRONT_W  = 16;
  localparam int COUNT_W  = 5;
  localparam int TOTAL_W  = 6;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GROUP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic step;
    logic resp;
  } cmd_t;

endpackage

// ===== hdl/role_fifo_group_matcher_unit.sv =====
// Top level of the role FIFO group matcher: three role rings and group pops.
//
//   channel   handshake            payload
//   input     start / busy         in_mode, in_role, in_player_id
//   result    out_valid (strobe)   out_front_*, out_count_*, out_total_waiting,
//                                  out_group_ready, out_status
//
// In each transaction the accepting edge updates the pointers,
// counts and ring memory, and the next cycle shows the result while the new
// front entries come out of the registered memory read port.
// No new transaction is accepted while a result is shown; busy is high then.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Synchronous reset empties all three rings; no clearing pass is needed.
module role_fifo_group_matcher_unit #(
  parameter int QUEUE_DEPTH = rfgm_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = rfgm_pkg::ID_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rfgm_pkg::MODE_W-1:0]       in_mode,
  input  logic [rfgm_pkg::ROLE_W-1:0]       in_role,
  input  logic [rfgm_pkg::PID_W-1:0]        in_player_id,
  output logic                              out_valid,
  output logic [rfgm_pkg::FRONT_W-1:0]      out_front_defender,
  output logic [rfgm_pkg::FRONT_W-1:0]      out_front_hunter,
  output logic [rfgm_pkg::FRONT_W-1:0]      out_front_bard,
  output logic [rfgm_pkg::COUNT_W-1:0]      out_count_defender,
  output logic [rfgm_pkg::COUNT_W-1:0]      out_count_hunter,
  output logic [rfgm_pkg::COUNT_W-1:0]      out_count_bard,
  output logic [rfgm_pkg::TOTAL_W-1:0]      out_total_waiting,
  output logic                              out_group_ready,
  output logic [rfgm_pkg::STATUS_W-1:0]     out_status
);

  rfgm_pkg::cmd_t cmd;

  rfgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rfgm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_mode            (in_mode),
    .in_role            (in_role),
    .in_player_id       (in_player_id),
    .out_front_defender (out_front_defender),
    .out_front_hunter   (out_front_hunter),
    .out_front_bard     (out_front_bard),
    .out_count_defender (out_count_defender),
    .out_count_hunter   (out_count_hunter),
    .out_count_bard     (out_count_bard),
    .out_total_waiting  (out_total_waiting),
    .out_group_ready    (out_group_ready),
    .out_status         (out_status)
  );

endmodule

// ===== hdl/rfgm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rfgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/rfgm_ctrl.sv =====
// Controller state machine that sequences one transaction and its result.
module rfgm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output rfgm_pkg::cmd_t    cmd
);

  rfgm_pkg::state_t state_r;
  rfgm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfgm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      rfgm_pkg::ST_IDLE: begin
        if (start) begin
          cmd.step  = 1'b1;
          state_nxt = rfgm_pkg::ST_RESP;
        end
      end
      rfgm_pkg::ST_RESP: begin
        busy      = 1'b1;
        out_valid = 1'b1;
        cmd.resp  = 1'b1;
        state_nxt = rfgm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rfgm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/rfgm_dp.sv =====
// Datapath with the three role rings, their pointers, counts and result fields.
module rfgm_dp #(
  parameter int QUEUE_DEPTH = rfgm_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = rfgm_pkg::ID_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rfgm_pkg::cmd_t                    cmd,
  input  logic [rfgm_pkg::MODE_W-1:0]       in_mode,
  input  logic [rfgm_pkg::ROLE_W-1:0]       in_role,
  input  logic [rfgm_pkg::PID_W-1:0]        in_player_id,
  output logic [rfgm_pkg::FRONT_W-1:0]      out_front_defender,
  output logic [rfgm_pkg::FRONT_W-1:0]      out_front_hunter,
  output logic [rfgm_pkg::FRONT_W-1:0]      out_front_bard,
  output logic [rfgm_pkg::COUNT_W-1:0]      out_count_defender,
  output logic [rfgm_pkg::COUNT_W-1:0]      out_count_hunter,
  output logic [rfgm_pkg::COUNT_W-1:0]      out_count_bard,
  output logic [rfgm_pkg::TOTAL_W-1:0]      out_total_waiting,
  output logic                              out_group_ready,
  output logic [rfgm_pkg::STATUS_W-1:0]     out_status
);

  localparam int NR = rfgm_pkg::NUM_ROLES;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 2;

  logic [AW-1:0]       head_r   [NR];
  logic [AW-1:0]       head_nxt [NR];
  logic [AW-1:0]       tail_r   [NR];
  logic [AW-1:0]       tail_nxt [NR];
  logic [CW-1:0]       cnt_r    [NR];
  logic [CW-1:0]       cnt_nxt  [NR];
  logic [NR-1:0]       push_ok;
  logic [NR-1:0]       pop_ok;
  logic [NR-1:0]       byp_r;
  logic [NR-1:0]       byp_nxt;
  logic [ID_WIDTH-1:0] byp_id_r;
  logic [ID_WIDTH-1:0] wdata;
  logic [ID_WIDTH-1:0] rdata    [NR];
  logic [ID_WIDTH-1:0] front_id [NR];
  logic [63:0]         pid_ext;
  logic [63:0]         front_ext [NR];
  logic [31:0]         cnt_ext   [NR];
  logic [31:0]         total_ext;
  logic [SW-1:0]       total;
  logic                group_ok;
  logic [rfgm_pkg::STATUS_W-1:0] status_r;
  logic [rfgm_pkg::STATUS_W-1:0] status_nxt;

  assign pid_ext = 64'(in_player_id);
  assign wdata   = pid_ext[ID_WIDTH-1:0];

  always_comb begin
    group_ok = 1'b1;
    for (int r = 0; r < NR; r++) begin
      if (cnt_r[r] == '0) begin
        group_ok = 1'b0;
      end
    end
    for (int r = 0; r < NR; r++) begin
      push_ok[r] = (in_mode == rfgm_pkg::MODE_PUSH) &&
                   (in_role == rfgm_pkg::ROLE_W'(r)) &&
                   (cnt_r[r] != CW'(QUEUE_DEPTH));
      pop_ok[r]  = ((in_mode == rfgm_pkg::MODE_POP) &&
                    (in_role == rfgm_pkg::ROLE_W'(r)) && (cnt_r[r] != '0)) ||
                   ((in_mode == rfgm_pkg::MODE_GROUP) && group_ok);
      head_nxt[r] = head_r[r];
      tail_nxt[r] = tail_r[r];
      cnt_nxt[r]  = cnt_r[r];
      byp_nxt[r]  = push_ok[r] && (cnt_r[r] == '0);
      if (push_ok[r]) begin
        tail_nxt[r] = (tail_r[r] == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r[r] + 1'b1;
        cnt_nxt[r]  = cnt_r[r] + 1'b1;
      end else if (pop_ok[r]) begin
        head_nxt[r] = (head_r[r] == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r[r] + 1'b1;
        cnt_nxt[r]  = cnt_r[r] - 1'b1;
      end
    end
    case (in_mode)
      rfgm_pkg::MODE_PUSH:  status_nxt = (push_ok != '0) ? rfgm_pkg::STAT_DONE
                                                          : rfgm_pkg::STAT_DROPPED;
      rfgm_pkg::MODE_POP:   status_nxt = (pop_ok != '0) ? rfgm_pkg::STAT_DONE
                                                         : rfgm_pkg::STAT_IGNORED;
      rfgm_pkg::MODE_GROUP: status_nxt = group_ok ? rfgm_pkg::STAT_DONE
                                                  : rfgm_pkg::STAT_IGNORED;
      default:              status_nxt = rfgm_pkg::STAT_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NR; r++) begin
        head_r[r] <= '0;
        tail_r[r] <= '0;
        cnt_r[r]  <= '0;
      end
    end else if (cmd.step) begin
      for (int r = 0; r < NR; r++) begin
        head_r[r] <= head_nxt[r];
        tail_r[r] <= tail_nxt[r];
        cnt_r[r]  <= cnt_nxt[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      byp_r    <= byp_nxt;
      byp_id_r <= wdata;
      status_r <= status_nxt;
    end
  end

  for (genvar g = 0; g < NR; g++) begin : g_ring
    rfgm_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (cmd.step && push_ok[g]),
      .waddr (tail_r[g]),
      .wdata (wdata),
      .raddr (head_nxt[g]),
      .rdata (rdata[g])
    );
  end

  always_comb begin
    for (int r = 0; r < NR; r++) begin
      if (cnt_r[r] == '0 || !cmd.resp) begin
        front_id[r] = '0;
      end else if (byp_r[r]) begin
        front_id[r] = byp_id_r;
      end else begin
        front_id[r] = rdata[r];
      end
      front_ext[r] = 64'(front_id[r]);
      cnt_ext[r]   = 32'(cnt_r[r]);
    end
    total     = SW'(cnt_r[0]) + SW'(cnt_r[1]) + SW'(cnt_r[2]);
    total_ext = 32'(total);
  end

  assign out_front_defender = front_ext[0][rfgm_pkg::FRONT_W-1:0];
  assign out_front_hunter   = front_ext[1][rfgm_pkg::FRONT_W-1:0];
  assign out_front_bard     = front_ext[2][rfgm_pkg::FRONT_W-1:0];
  assign out_count_defender = cnt_ext[0][rfgm_pkg::COUNT_W-1:0];
  assign out_count_hunter   = cnt_ext[1][rfgm_pkg::COUNT_W-1:0];
  assign out_count_bard     = cnt_ext[2][rfgm_pkg::COUNT_W-1:0];
  assign out_total_waiting  = total_ext[rfgm_pkg::TOTAL_W-1:0];
  assign out_group_ready    = group_ok;
  assign out_status         = status_r;

endmodule

// ===== tb/role_fifo_group_matcher_unit_test.sv =====
// Self-checking testbench for the role FIFO group matcher with a predicting scoreboard.
`timescale 1ns / 100ps

module role_fifo_group_matcher_unit_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 6;

  localparam logic [rfgm_pkg::ROLE_W-1:0] ROLE_DEFENDER = 2'd0;
  localparam logic [rfgm_pkg::ROLE_W-1:0] ROLE_HUNTER   = 2'd1;
  localparam logic [rfgm_pkg::ROLE_W-1:0] ROLE_BARD     = 2'd2;
  localparam logic [rfgm_pkg::ROLE_W-1:0] ROLE_NONE     = 2'd3;

  typedef struct packed {
    logic [rfgm_pkg::FRONT_W-1:0]  front_defender;
    logic [rfgm_pkg::FRONT_W-1:0]  front_hunter;
    logic [rfgm_pkg::FRONT_W-1:0]  front_bard;
    logic [rfgm_pkg::COUNT_W-1:0]  count_defender;
    logic [rfgm_pkg::COUNT_W-1:0]  count_hunter;
    logic [rfgm_pkg::COUNT_W-1:0]  count_bard;
    logic [rfgm_pkg::TOTAL_W-1:0]  total_waiting;
    logic                          group_ready;
    logic [rfgm_pkg::STATUS_W-1:0] status;
  } queue_report_t;

  class role_queue_tracker;
    logic [rfgm_pkg::PID_W-1:0] ring [rfgm_pkg::NUM_ROLES][rfgm_pkg::QUEUE_DEPTH_DEF];
    int head [rfgm_pkg::NUM_ROLES];
    int tail [rfgm_pkg::NUM_ROLES];
    int fill [rfgm_pkg::NUM_ROLES];
    queue_report_t pending_reports[$];
    int mismatch_count;

    function new();
      for (int r = 0; r < rfgm_pkg::NUM_ROLES; r++) begin
        head[r] = 0;
        tail[r] = 0;
        fill[r] = 0;
      end
      mismatch_count = 0;
    endfunction

    function int next_slot(int idx);
      return (idx + 1 >= rfgm_pkg::QUEUE_DEPTH_DEF) ? 0 : idx + 1;
    endfunction

    function bit has_group();
      return fill[0] > 0 && fill[1] > 0 && fill[2] > 0;
    endfunction

    function logic [rfgm_pkg::FRONT_W-1:0] front_of(int r);
      return (fill[r] == 0) ? '0 : ring[r][head[r]];
    endfunction

    function void retire_front(int r);
      head[r] = next_slot(head[r]);
      fill[r] = fill[r] - 1;
    endfunction

    function void note_command(logic [rfgm_pkg::MODE_W-1:0] mode,
                               logic [rfgm_pkg::ROLE_W-1:0] role,
                               logic [rfgm_pkg::PID_W-1:0] pid);
      queue_report_t rpt;
      logic [rfgm_pkg::STATUS_W-1:0] stat;
      stat = rfgm_pkg::STAT_DONE;
      case (mode)
        rfgm_pkg::MODE_PUSH: begin
          if (role > ROLE_BARD || fill[role] >= rfgm_pkg::QUEUE_DEPTH_DEF) begin
            stat = rfgm_pkg::STAT_DROPPED;
          end else begin
            ring[role][tail[role]] = pid;
            tail[role] = next_slot(tail[role]);
            fill[role] = fill[role] + 1;
          end
        end
        rfgm_pkg::MODE_POP: begin
          if (role > ROLE_BARD || fill[role] == 0) begin
            stat = rfgm_pkg::STAT_IGNORED;
          end else begin
            retire_front(role);
          end
        end
        rfgm_pkg::MODE_GROUP: begin
          if (has_group()) begin
            for (int r = 0; r < rfgm_pkg::NUM_ROLES; r++) retire_front(r);
          end else begin
            stat = rfgm_pkg::STAT_IGNORED;
          end
        end
        default: ;
      endcase
      rpt.front_defender = front_of(0);
      rpt.front_hunter   = front_of(1);
      rpt.front_bard     = front_of(2);
      rpt.count_defender = rfgm_pkg::COUNT_W'(fill[0]);
      rpt.count_hunter   = rfgm_pkg::COUNT_W'(fill[1]);
      rpt.count_bard     = rfgm_pkg::COUNT_W'(fill[2]);
      rpt.total_waiting  = rfgm_pkg::TOTAL_W'(fill[0] + fill[1] + fill[2]);
      rpt.group_ready    = has_group();
      rpt.status         = stat;
      pending_reports.push_back(rpt);
    endfunction

    function void compare_field(string name, logic [rfgm_pkg::FRONT_W-1:0] want,
                                logic [rfgm_pkg::FRONT_W-1:0] seen);
      if (seen !== want) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, seen);
        mismatch_count++;
      end
    endfunction

    function void check_report(queue_report_t got);
      queue_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: result with no transaction outstanding, expected none, actual %h",
                 $time, got);
        mismatch_count++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("front_defender", want.front_defender, got.front_defender);
      compare_field("front_hunter", want.front_hunter, got.front_hunter);
      compare_field("front_bard", want.front_bard, got.front_bard);
      compare_field("count_defender", want.count_defender, got.count_defender);
      compare_field("count_hunter", want.count_hunter, got.count_hunter);
      compare_field("count_bard", want.count_bard, got.count_bard);
      compare_field("total_waiting", want.total_waiting, got.total_waiting);
      compare_field("group_ready", want.group_ready, got.group_ready);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [rfgm_pkg::MODE_W-1:0]   in_mode;
  logic [rfgm_pkg::ROLE_W-1:0]   in_role;
  logic [rfgm_pkg::PID_W-1:0]    in_player_id;
  logic                          out_valid;
  logic [rfgm_pkg::FRONT_W-1:0]  out_front_defender;
  logic [rfgm_pkg::FRONT_W-1:0]  out_front_hunter;
  logic [rfgm_pkg::FRONT_W-1:0]  out_front_bard;
  logic [rfgm_pkg::COUNT_W-1:0]  out_count_defender;
  logic [rfgm_pkg::COUNT_W-1:0]  out_count_hunter;
  logic [rfgm_pkg::COUNT_W-1:0]  out_count_bard;
  logic [rfgm_pkg::TOTAL_W-1:0]  out_total_waiting;
  logic                          out_group_ready;
  logic [rfgm_pkg::STATUS_W-1:0] out_status;

  role_queue_tracker tracker;
  int cycle_count;

  role_fifo_group_matcher_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_role            (in_role),
    .in_player_id       (in_player_id),
    .out_valid          (out_valid),
    .out_front_defender (out_front_defender),
    .out_front_hunter   (out_front_hunter),
    .out_front_bard     (out_front_bard),
    .out_count_defender (out_count_defender),
    .out_count_hunter   (out_count_hunter),
    .out_count_bard     (out_count_bard),
    .out_total_waiting  (out_total_waiting),
    .out_group_ready    (out_group_ready),
    .out_status         (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("role_fifo_group_matcher_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    queue_report_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      got.front_defender = out_front_defender;
      got.front_hunter   = out_front_hunter;
      got.front_bard     = out_front_bard;
      got.count_defender = out_count_defender;
      got.count_hunter   = out_count_hunter;
      got.count_bard     = out_count_bard;
      got.total_waiting  = out_total_waiting;
      got.group_ready    = out_group_ready;
      got.status         = out_status;
      tracker.check_report(got);
    end
  end

  function automatic int pick_idle(bit quiet);
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 8);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction is accepted.
  task automatic issue_command(logic [rfgm_pkg::MODE_W-1:0] mode,
                               logic [rfgm_pkg::ROLE_W-1:0] role,
                               logic [rfgm_pkg::PID_W-1:0] pid, int idle);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    start        <= 1'b1;
    in_mode      <= mode;
    in_role      <= role;
    in_player_id <= pid;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    tracker.note_command(mode, role, pid);
    @(negedge clk);
  endtask

  initial begin
    int issued;
    int seg_len;
    int push_pct;
    logic [rfgm_pkg::MODE_W-1:0] mode;
    logic [rfgm_pkg::ROLE_W-1:0] role;
    logic [rfgm_pkg::PID_W-1:0] pid;

    tracker      = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_mode      = rfgm_pkg::MODE_QUERY;
    in_role      = ROLE_DEFENDER;
    in_player_id = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    issue_command(rfgm_pkg::MODE_QUERY, ROLE_NONE, 16'hFFFF, pick_idle(1'b0));
    issue_command(rfgm_pkg::MODE_POP, ROLE_DEFENDER, '0, pick_idle(1'b0));
    issue_command(rfgm_pkg::MODE_POP, ROLE_NONE, '0, pick_idle(1'b0));
    issue_command(rfgm_pkg::MODE_GROUP, ROLE_HUNTER, '0, pick_idle(1'b0));
    issue_command(rfgm_pkg::MODE_PUSH, ROLE_NONE, 16'h1234, pick_idle(1'b0));
    issue_command(rfgm_pkg::MODE_PUSH, ROLE_DEFENDER, 16'hFFFF, pick_idle(1'b0));
    issue_command(rfgm_pkg::MODE_PUSH, ROLE_HUNTER, 16'h0000, pick_idle(1'b0));
    issue_command(rfgm_pkg::MODE_GROUP, ROLE_NONE, '0, pick_idle(1'b0));
    issue_command(rfgm_pkg::MODE_PUSH, ROLE_BARD, 16'hA5A5, pick_idle(1'b0));
    issue_command(rfgm_pkg::MODE_GROUP, ROLE_NONE, '0, pick_idle(1'b0));
    for (int i = 0; i < rfgm_pkg::QUEUE_DEPTH_DEF + 1; i++) begin
      issue_command(rfgm_pkg::MODE_PUSH, ROLE_DEFENDER,
                    rfgm_pkg::PID_W'(16'h5A00 + i), pick_idle(1'b0));
    end

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 20;
      endcase
      for (int k = 0; k < seg_len && issued < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          mode = rfgm_pkg::MODE_PUSH;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: mode = rfgm_pkg::MODE_POP;
            5, 6, 7:       mode = rfgm_pkg::MODE_GROUP;
            default:       mode = rfgm_pkg::MODE_QUERY;
          endcase
        end
        role = ($urandom_range(0, 19) == 0) ? ROLE_NONE
                                            : rfgm_pkg::ROLE_W'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
          0:       pid = '0;
          1:       pid = '1;
          default: pid = rfgm_pkg::PID_W'($urandom_range(0, 65535));
        endcase
        issue_command(mode, role, pid, pick_idle(issued >= RANDOM_ITEMS - QUIET_ITEMS));
        issued++;
      end
    end
    start <= 1'b0;

    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending_reports.size() == 0) begin
      $display("role_fifo_group_matcher_unit: match");
    end else begin
      $display("role_fifo_group_matcher_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rfgm_pkg.sv
hdl/rfgm_ram.sv
hdl/rfgm_ctrl.sv
hdl/rfgm_dp.sv
hdl/role_fifo_group_matcher_unit.sv
tb/role_fifo_group_matcher_unit_test.sv
